// ===== hw/rtl/nfbta_pkg.sv =====
`default_nettype none

package nfbta_pkg;

  // Default heap geometry.
  localparam int unsigned HEAP_BYTES_DEF  = 1048576;
  localparam int unsigned CHUNK_BYTES_DEF = 4096;

  // Port field widths.
  localparam int OPCODE_W = 2;
  localparam int ADDR_W   = 20;
  localparam int REQ_W    = 21;
  localparam int WORD_W   = 32;

  // Fixed heap layout: prologue payload, first real block payload, smallest block.
  localparam int unsigned PROLOGUE_BP = 8;
  localparam int unsigned FIRST_BP    = 16;
  localparam int unsigned MIN_BLOCK   = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfbta_ram.sv =====
`default_nettype none

module nfbta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/next_fit_boundary_tag_allocator_unit.sv =====
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+-------------------------------
// request   | in_opcode, in_block_addr, in_req_bytes       | taken when start && !busy
// result    | out_result_addr, out_failed                  | out_valid, one cycle, no stall
//
// Steps: every block header that a request visits is one read of the single heap RAM,
// followed by its registered data. Allocate walks next-fit from the rover; free checks
// the address by walking from the heap start. On top come 2 to 4 writes to place a block,
// 3 to grow the heap, and 2 neighbour reads plus up to 2 writes to coalesce. A closing
// state registers the result, which shows on the strobe in the cycle after it.
// Reset: after rst_n rises, 5 cycles write the prologue, the first free chunk and the
// epilogue, with busy high; the rest of the heap RAM is left as it is.
// Stalls: the receiver cannot stall; the result strobe is shown for one cycle.
`default_nettype none

module next_fit_boundary_tag_allocator_unit #(
  parameter int unsigned HEAP_BYTES  = nfbta_pkg::HEAP_BYTES_DEF,
  parameter int unsigned CHUNK_BYTES = nfbta_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [nfbta_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [nfbta_pkg::ADDR_W-1:0]     in_block_addr,
  input  wire logic [nfbta_pkg::REQ_W-1:0]      in_req_bytes,
  output logic                                  out_valid,
  output logic      [nfbta_pkg::ADDR_W-1:0]     out_result_addr,
  output logic                                  out_failed
);

  import nfbta_pkg::*;

  // Byte offsets and block sizes share one width: wide enough for the sum of an
  // offset and a size inside the heap, and for the largest rounded request.
  localparam int HB_W   = $clog2(HEAP_BYTES);
  localparam int AW     = (HB_W + 2 > REQ_W + 2) ? HB_W + 2 : REQ_W + 2;
  localparam int DEPTH  = HEAP_BYTES / 4;
  localparam int MW     = $clog2(DEPTH);

  // The chunk is rounded up to a whole number of double words, as the heap grows.
  localparam int unsigned CHUNK_WORDS = CHUNK_BYTES / 4;
  localparam int unsigned CHUNK_RND   = (CHUNK_WORDS + CHUNK_WORDS % 2) * 4;

  typedef logic [AW-1:0] addr_t;

  localparam addr_t HEAP_LIM     = addr_t'(HEAP_BYTES);
  localparam addr_t HEAP_TOP_RST = addr_t'(FIRST_BP + CHUNK_RND);
  localparam addr_t CHUNK_SZ     = addr_t'(CHUNK_BYTES);
  localparam addr_t CHUNK_RND_SZ = addr_t'(CHUNK_RND);
  localparam addr_t MIN_SZ       = addr_t'(MIN_BLOCK);
  localparam addr_t PRO_BP       = addr_t'(PROLOGUE_BP);
  localparam addr_t FIRST_ADDR   = addr_t'(FIRST_BP);
  localparam addr_t ALLOC_FLAG   = addr_t'(1);
  localparam addr_t LOW_MASK     = addr_t'(7);

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_SRCH_HDR,
    S_SRCH_HW,
    S_LOOP,
    S_LOOP_W,
    S_GROW,
    S_MERGE_A,
    S_MERGE_B,
    S_MERGE_C,
    S_MERGE_W,
    S_SETTLE,
    S_LIVE0,
    S_LIVE_RD,
    S_LIVE_W,
    S_CLR,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  opcode_t op_r, op_nxt;
  addr_t   blk_r, blk_nxt;
  addr_t   need_r, need_nxt;
  addr_t   bp_r, bp_nxt;
  addr_t   s_r, s_nxt;
  addr_t   top_r, top_nxt;
  addr_t   rover_r, rover_nxt;
  logic    phase2_r, phase2_nxt;
  logic    from_grow_r, from_grow_nxt;
  logic    pa_r, pa_nxt;
  logic    na_r, na_nxt;
  addr_t   ps_r, ps_nxt;
  addr_t   ns_r, ns_nxt;
  addr_t   res_r, res_nxt;
  logic    fail_r, fail_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic    out_failed_r, out_failed_nxt;

  // Heap RAM port signals.
  logic              wr_en;
  logic [MW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [MW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  function automatic logic [MW-1:0] widx(addr_t a);
    return a[MW+1:2];
  endfunction

  function automatic logic [WORD_W-1:0] wword(addr_t v);
    return WORD_W'(v);
  endfunction

  nfbta_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_heap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  opcode_t op_in;
  addr_t   req_ext;
  addr_t   need_in;
  addr_t   rd_size;
  logic    rd_alloc;
  addr_t   nx;
  addr_t   rem;
  logic    split;
  addr_t   grow_sz;
  logic    grow_ok;
  addr_t   total;
  addr_t   prev;

  assign op_in    = opcode_t'(in_opcode);
  assign req_ext  = addr_t'(in_req_bytes);
  // Round the payload up to double words and add the header and footer.
  assign need_in  = (req_ext <= addr_t'(8)) ? MIN_SZ : ((req_ext + addr_t'(15)) & ~LOW_MASK);
  assign rd_size  = addr_t'(rd_data) & ~LOW_MASK;
  assign rd_alloc = rd_data[0];
  assign nx       = bp_r + s_r;
  assign rem      = s_r - need_r;
  assign split    = rem >= MIN_SZ;
  assign grow_sz  = (need_r > CHUNK_SZ) ? need_r : CHUNK_RND_SZ;
  assign grow_ok  = grow_sz <= (HEAP_LIM - top_r);
  // Coalesced size: the freed block plus each neighbour that is free.
  assign total    = s_r + (pa_r ? '0 : ps_r) + (na_r ? '0 : ns_r);
  assign prev     = bp_r - ps_r;

  always_comb begin
    logic do_alloc;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    need_nxt       = need_r;
    bp_nxt         = bp_r;
    s_nxt          = s_r;
    top_nxt        = top_r;
    rover_nxt      = rover_r;
    phase2_nxt     = phase2_r;
    from_grow_nxt  = from_grow_r;
    pa_nxt         = pa_r;
    na_nxt         = na_r;
    ps_nxt         = ps_r;
    ns_nxt         = ns_r;
    res_nxt        = res_r;
    fail_nxt       = fail_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_failed_nxt = out_failed_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_addr        = '0;
    do_alloc       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // Prologue header and footer, first chunk and epilogue.
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        unique case (cnt_r)
          3'd0: begin
            wr_addr = widx(addr_t'(4));
            wr_data = wword(PRO_BP | ALLOC_FLAG);
          end
          3'd1: begin
            wr_addr = widx(PRO_BP);
            wr_data = wword(PRO_BP | ALLOC_FLAG);
          end
          3'd2: begin
            wr_addr = widx(FIRST_ADDR - addr_t'(4));
            wr_data = wword(CHUNK_RND_SZ);
          end
          3'd3: begin
            wr_addr = widx(HEAP_TOP_RST - addr_t'(8));
            wr_data = wword(CHUNK_RND_SZ);
          end
          default: begin
            wr_addr   = widx(HEAP_TOP_RST - addr_t'(4));
            wr_data   = wword(ALLOC_FLAG);
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_IDLE: begin
        if (start) begin
          res_nxt  = '0;
          fail_nxt = 1'b0;
          op_nxt   = op_in;
          blk_nxt  = addr_t'(in_block_addr);
          need_nxt = need_in;
          unique case (op_in)
            OP_ALLOC: do_alloc = 1'b1;
            OP_FREE:  state_nxt = S_LIVE0;
            OP_REALLOC: begin
              priority if (in_block_addr == '0) begin
                do_alloc = 1'b1;
              end else if (in_req_bytes == '0) begin
                fail_nxt  = 1'b1;
                state_nxt = S_LIVE0;
              end else begin
                do_alloc = 1'b1;
              end
            end
            OP_NOP:   state_nxt = S_DONE;
          endcase
          if (do_alloc) begin
            if (in_req_bytes == '0) begin
              fail_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              phase2_nxt = 1'b0;
              bp_nxt     = rover_r;
              state_nxt  = S_SRCH_HDR;
            end
          end
        end
      end

      S_SRCH_HDR: begin
        rd_addr   = widx(bp_r - addr_t'(4));
        state_nxt = S_SRCH_HW;
      end

      S_SRCH_HW: begin
        s_nxt     = rd_size;
        state_nxt = S_LOOP;
      end

      S_LOOP: begin
        if ((phase2_r && bp_r == rover_r) || s_r == '0 || nx >= top_r) begin
          priority if (!phase2_r) begin
            // Wrap round to the start of the heap.
            phase2_nxt = 1'b1;
            bp_nxt     = PRO_BP;
            state_nxt  = S_SRCH_HDR;
          end else if (grow_ok) begin
            bp_nxt    = top_r;
            s_nxt     = grow_sz;
            cnt_nxt   = '0;
            state_nxt = S_GROW;
          end else begin
            res_nxt   = '0;
            fail_nxt  = 1'b1;
            state_nxt = S_DONE;
          end
        end else begin
          rd_addr   = widx(nx - addr_t'(4));
          bp_nxt    = nx;
          state_nxt = S_LOOP_W;
        end
      end

      S_LOOP_W: begin
        s_nxt = rd_size;
        if (!rd_alloc && rd_size >= need_r) begin
          cnt_nxt   = '0;
          state_nxt = S_SETTLE;
        end else begin
          state_nxt = S_LOOP;
        end
      end

      S_GROW: begin
        wr_en   = 1'b1;
        wr_data = wword(s_r);
        cnt_nxt = cnt_r + 3'd1;
        unique case (cnt_r)
          3'd0: wr_addr = widx(bp_r - addr_t'(4));
          3'd1: wr_addr = widx(nx - addr_t'(8));
          default: begin
            // New epilogue at the moved top of the heap.
            wr_addr       = widx(nx - addr_t'(4));
            wr_data       = wword(ALLOC_FLAG);
            top_nxt       = nx;
            from_grow_nxt = 1'b1;
            state_nxt     = S_MERGE_A;
          end
        endcase
      end

      S_MERGE_A: begin
        rd_addr   = widx(bp_r - addr_t'(8));
        state_nxt = S_MERGE_B;
      end

      S_MERGE_B: begin
        pa_nxt    = rd_alloc;
        ps_nxt    = rd_size;
        rd_addr   = widx(nx - addr_t'(4));
        state_nxt = S_MERGE_C;
      end

      S_MERGE_C: begin
        na_nxt    = rd_alloc;
        ns_nxt    = rd_size;
        cnt_nxt   = '0;
        state_nxt = S_MERGE_W;
      end

      S_MERGE_W: begin
        logic fin;
        fin = 1'b0;
        if (pa_r && na_r) begin
          fin = 1'b1;
        end else if (cnt_r == 3'd0) begin
          wr_en   = 1'b1;
          wr_addr = pa_r ? widx(bp_r - addr_t'(4)) : widx(prev - addr_t'(4));
          wr_data = wword(total);
          cnt_nxt = 3'd1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = na_r ? widx(nx - addr_t'(8)) : widx(nx + ns_r - addr_t'(8));
          wr_data = wword(total);
          fin     = 1'b1;
        end
        if (fin) begin
          bp_nxt    = pa_r ? bp_r : prev;
          rover_nxt = pa_r ? bp_r : prev;
          s_nxt     = total;
          cnt_nxt   = '0;
          state_nxt = from_grow_r ? S_SETTLE : S_DONE;
        end
      end

      S_SETTLE: begin
        logic fin;
        fin     = 1'b0;
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        unique case (cnt_r)
          3'd0: begin
            wr_addr = widx(bp_r - addr_t'(4));
            wr_data = wword(split ? (need_r | ALLOC_FLAG) : (s_r | ALLOC_FLAG));
          end
          3'd1: begin
            if (split) begin
              wr_addr = widx(bp_r + need_r - addr_t'(8));
              wr_data = wword(need_r | ALLOC_FLAG);
            end else begin
              wr_addr = widx(nx - addr_t'(8));
              wr_data = wword(s_r | ALLOC_FLAG);
              fin     = 1'b1;
            end
          end
          3'd2: begin
            wr_addr = widx(bp_r + need_r - addr_t'(4));
            wr_data = wword(rem);
          end
          default: begin
            wr_addr = widx(nx - addr_t'(8));
            wr_data = wword(rem);
            fin     = 1'b1;
          end
        endcase
        if (fin) begin
          rover_nxt = bp_r;
          res_nxt   = bp_r;
          fail_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = (op_r == OP_REALLOC && blk_r != '0) ? S_LIVE0 : S_DONE;
        end
      end

      S_LIVE0: begin
        if (blk_r == '0 || (blk_r & LOW_MASK) != '0) begin
          state_nxt = S_DONE;
        end else begin
          bp_nxt    = FIRST_ADDR;
          state_nxt = S_LIVE_RD;
        end
      end

      S_LIVE_RD: begin
        if (bp_r < top_r && bp_r <= blk_r) begin
          rd_addr   = widx(bp_r - addr_t'(4));
          state_nxt = S_LIVE_W;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_LIVE_W: begin
        s_nxt = rd_size;
        priority if (rd_size == '0) begin
          state_nxt = S_DONE;
        end else if (bp_r == blk_r) begin
          cnt_nxt   = '0;
          state_nxt = rd_alloc ? S_CLR : S_DONE;
        end else begin
          bp_nxt    = bp_r + rd_size;
          state_nxt = S_LIVE_RD;
        end
      end

      S_CLR: begin
        wr_en   = 1'b1;
        wr_data = wword(s_r);
        if (cnt_r == 3'd0) begin
          wr_addr = widx(bp_r - addr_t'(4));
          cnt_nxt = 3'd1;
        end else begin
          wr_addr       = widx(nx - addr_t'(8));
          from_grow_nxt = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = S_MERGE_A;
        end
      end

      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = res_r[ADDR_W-1:0];
        out_failed_nxt = fail_r;
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      top_r       <= HEAP_TOP_RST;
      rover_r     <= FIRST_ADDR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      rover_r     <= rover_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    need_r       <= need_nxt;
    bp_r         <= bp_nxt;
    s_r          <= s_nxt;
    phase2_r     <= phase2_nxt;
    from_grow_r  <= from_grow_nxt;
    pa_r         <= pa_nxt;
    na_r         <= na_nxt;
    ps_r         <= ps_nxt;
    ns_r         <= ns_nxt;
    res_r        <= res_nxt;
    fail_r       <= fail_nxt;
    out_addr_r   <= out_addr_nxt;
    out_failed_r <= out_failed_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_failed      = out_failed_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nfbta_checker.sv =====
`default_nettype none

module nfbta_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic [nfbta_pkg::ADDR_W-1:0] out_result_addr,
  input wire logic                         out_failed
);

  // A taken request always occupies the block on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Every result closes a request that was being worked on.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failed) |-> (out_result_addr == '0))
    else $error("failed result carries an address");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_addr[2:0] == 3'b000))
    else $error("granted address not double-word aligned");

endmodule

bind next_fit_boundary_tag_allocator_unit nfbta_checker u_nfbta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_addr (out_result_addr),
  .out_failed      (out_failed)
);

`default_nettype wire

// ===== test/tb_next_fit_boundary_tag_allocator_unit.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the next-fit boundary-tag heap allocator.
// The block's heap is mirrored word for word in a predictor here.
// Every accepted request is run through that predictor at once.
// Every result strobe is then checked against the oldest prediction.
module tb_next_fit_boundary_tag_allocator_unit;
  import nfbta_pkg::*;

  localparam int unsigned HEAP_B    = HEAP_BYTES_DEF;
  localparam int unsigned CHUNK_B   = CHUNK_BYTES_DEF;
  localparam int unsigned N_WORDS   = HEAP_B / 4;
  localparam int unsigned SZ_MASK   = ~32'h7;
  localparam int          IDLE_LIMIT = 400000;
  localparam int          N_RANDOM  = 800;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              failed;
  } grant_t;

  // Holds the outstanding predicted grants and counts mismatches.
  class grant_scoreboard;
    grant_t pending[$];
    int     errors;
    int     checked;

    function void note_request(grant_t g);
      pending.push_back(g);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (pending.size() == 0) begin
        $error("grant with no request outstanding: addr %0d failed %0d", got.addr, got.failed);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.addr !== got.addr) begin
        $error("out_result_addr: expected %0d, actual %0d", want.addr, got.addr);
        errors++;
      end
      if (want.failed !== got.failed) begin
        $error("out_failed: expected %0d, actual %0d", want.failed, got.failed);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OPCODE_W-1:0] in_opcode;
  logic [ADDR_W-1:0]   in_block_addr;
  logic [REQ_W-1:0]    in_req_bytes;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_result_addr;
  logic                out_failed;

  grant_scoreboard sb;

  next_fit_boundary_tag_allocator_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_block_addr   (in_block_addr),
    .in_req_bytes    (in_req_bytes),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_failed      (out_failed)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Heap mirror. Words never written read as zero; the block never reads
  // such words, since every walk stays below the heap top.
  // ---------------------------------------------------------------------
  int unsigned heap_mem[N_WORDS];
  int unsigned brk_top;
  int unsigned next_fit_start;

  function automatic int unsigned hp_rd(int unsigned a);
    return ((a >> 2) < N_WORDS) ? heap_mem[a >> 2] : 0;
  endfunction

  function automatic void hp_wr(int unsigned a, int unsigned v);
    if ((a >> 2) < N_WORDS) heap_mem[a >> 2] = v;
  endfunction

  function automatic int unsigned blk_size(int unsigned bp);
    return hp_rd(bp - 4) & SZ_MASK;
  endfunction

  // Merges a newly free block with whichever neighbours are free too, and
  // leaves the next-fit start on the merged block.
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned s, total, prev, nx, ns;
    bit prev_used, next_used;
    s = blk_size(bp);
    prev_used = ((hp_rd(bp - 8) & 1) != 0);
    next_used = ((hp_rd(bp + s - 4) & 1) != 0);
    total = s;
    if (prev_used && !next_used) begin
      total += blk_size(bp + s);
      hp_wr(bp - 4, total);
      hp_wr(bp + total - 8, total);
    end else if (!prev_used && next_used) begin
      prev = bp - (hp_rd(bp - 8) & SZ_MASK);
      total += blk_size(prev);
      hp_wr(bp + s - 8, total);
      hp_wr(prev - 4, total);
      bp = prev;
    end else if (!prev_used && !next_used) begin
      prev = bp - (hp_rd(bp - 8) & SZ_MASK);
      nx = bp + s;
      ns = blk_size(nx);
      total += blk_size(prev) + ns;
      hp_wr(prev - 4, total);
      hp_wr(nx + ns - 8, total);
      bp = prev;
    end
    next_fit_start = bp;
    return bp;
  endfunction

  function automatic int unsigned raise_brk(int unsigned bytes);
    int unsigned words, sz, bp;
    words = bytes / 4;
    if (words & 1) words++;
    sz = words * 4;
    if (sz == 0 || sz > HEAP_B - brk_top) return 0;
    bp = brk_top;
    hp_wr(bp - 4, sz);
    hp_wr(bp + sz - 8, sz);
    hp_wr(bp + sz - 4, 1);
    brk_top += sz;
    return coalesce(bp);
  endfunction

  // Next-fit: from just past the start block to the epilogue, then from
  // the heap start round to the start block itself.
  function automatic int unsigned scan_for_room(int unsigned need);
    int unsigned bp, s, nx, h;
    bp = next_fit_start;
    forever begin
      s = blk_size(bp);
      if (s == 0) break;
      nx = bp + s;
      if (nx >= brk_top) break;
      h = hp_rd(nx - 4);
      if ((h & SZ_MASK) == 0) break;
      bp = nx;
      if (!(h & 1) && (h & SZ_MASK) >= need) return bp;
    end
    bp = PROLOGUE_BP;
    while (bp != next_fit_start) begin
      s = blk_size(bp);
      if (s == 0) break;
      nx = bp + s;
      if (nx >= brk_top) break;
      bp = nx;
      h = hp_rd(bp - 4);
      if (!(h & 1) && (h & SZ_MASK) >= need) return bp;
    end
    return 0;
  endfunction

  function automatic void place_block(int unsigned bp, int unsigned need);
    int unsigned s;
    s = blk_size(bp);
    if (s - need >= MIN_BLOCK) begin
      hp_wr(bp - 4, need | 1);
      hp_wr(bp + need - 8, need | 1);
      hp_wr(bp + need - 4, s - need);
      hp_wr(bp + s - 8, s - need);
    end else begin
      hp_wr(bp - 4, s | 1);
      hp_wr(bp + s - 8, s | 1);
    end
    next_fit_start = bp;
  endfunction

  function automatic int unsigned carve(int unsigned req);
    int unsigned need, bp;
    if (req == 0) return 0;
    need = (req <= 8) ? MIN_BLOCK : 8 * ((req + 15) / 8);
    bp = scan_for_room(need);
    if (bp == 0) begin
      bp = raise_brk((need > CHUNK_B) ? need : CHUNK_B);
      if (bp == 0) return 0;
    end
    place_block(bp, need);
    return bp;
  endfunction

  function automatic bit owns_block(int unsigned bp);
    int unsigned a, h, s;
    a = FIRST_BP;
    if (bp == 0 || (bp & 7) != 0) return 0;
    while (a < brk_top && a <= bp) begin
      h = hp_rd(a - 4);
      s = h & SZ_MASK;
      if (s == 0) break;
      if (a == bp) return h[0];
      a += s;
    end
    return 0;
  endfunction

  function automatic void give_back(int unsigned bp);
    int unsigned s;
    if (!owns_block(bp)) return;
    s = blk_size(bp);
    hp_wr(bp - 4, s);
    hp_wr(bp + s - 8, s);
    void'(coalesce(bp));
  endfunction

  function automatic void heap_reset();
    foreach (heap_mem[i]) heap_mem[i] = 0;
    hp_wr(4, 8 | 1);
    hp_wr(8, 8 | 1);
    hp_wr(12, 1);
    brk_top = FIRST_BP;
    next_fit_start = PROLOGUE_BP;
    void'(raise_brk(CHUNK_B));
  endfunction

  // Payload offsets currently held by the stimulus, so that most frees
  // and reallocations name a real block.
  int unsigned held[$];

  function automatic void forget_block(int unsigned bp);
    foreach (held[i]) if (held[i] == bp) begin
      held.delete(i);
      return;
    end
  endfunction

  function automatic grant_t predict_request(opcode_t op, int unsigned addr, int unsigned req);
    grant_t g;
    int unsigned r;
    bit was_held;
    r = 0;
    g.failed = 1'b0;
    was_held = owns_block(addr);
    case (op)
      OP_ALLOC: begin
        r = carve(req);
        g.failed = (r == 0);
      end
      OP_FREE: begin
        give_back(addr);
        if (was_held) forget_block(addr);
      end
      OP_REALLOC: begin
        if (addr == 0) begin
          r = carve(req);
          g.failed = (r == 0);
        end else if (req == 0) begin
          give_back(addr);
          if (was_held) forget_block(addr);
          g.failed = 1'b1;
        end else begin
          r = carve(req);
          if (r != 0) begin
            give_back(addr);
            if (was_held) forget_block(addr);
          end
          g.failed = (r == 0);
        end
      end
      default: ;
    endcase
    if (r != 0) held.push_back(r);
    g.addr = r[ADDR_W-1:0];
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // Driving and monitoring.
  // ---------------------------------------------------------------------
  int idle_cycles;
  int n_sent;

  // Presents one request and holds it until the block takes it. A zero
  // gap leaves start high so that the next request follows back to back.
  task automatic send_request(opcode_t op, int unsigned addr, int unsigned req, int gap);
    start         <= 1'b1;
    in_opcode     <= op;
    in_block_addr <= addr[ADDR_W-1:0];
    in_req_bytes  <= req[REQ_W-1:0];
    do @(posedge clk); while (busy);
    // The block sees the truncated fields, so the predictor does too.
    sb.note_request(predict_request(op, addr & 32'hFFFFF, req & 32'h1FFFFF));
    idle_cycles = 0;
    n_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Mostly small sizes so that the heap holds many blocks; now and then a
  // large one that forces growth or is refused outright.
  function automatic int unsigned pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3)  return 0;
    if (p < 60) return $urandom_range(1, 64);
    if (p < 90) return $urandom_range(65, 1024);
    if (p < 98) return $urandom_range(1025, 16384);
    return $urandom_range(16385, 1 << 20);
  endfunction

  function automatic int unsigned pick_held();
    if (held.size() == 0) return 0;
    return held[$urandom_range(0, held.size() - 1)];
  endfunction

  // A free or reallocate address that is wrong in one of the ways the
  // block must tolerate: interior, misaligned, beyond the heap or random.
  function automatic int unsigned pick_bad_addr();
    case ($urandom_range(0, 3))
      0: return pick_held() + 8;
      1: return pick_held() + $urandom_range(1, 7);
      2: return $urandom_range(brk_top, (1 << ADDR_W) - 1);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_grant('{addr: out_result_addr, failed: out_failed});
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // Watchdog: ends the run if nothing moves for far longer than the
  // slowest walk of the largest heap this stimulus can build.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_cycles > IDLE_LIMIT) begin
        $display("timeout with %0d requests outstanding", sb.pending.size());
        $display("tb_next_fit_boundary_tag_allocator_unit failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned a;
    int          p;
    sb = new();
    idle_cycles = 0;
    n_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_NOP;
    in_block_addr = '0;
    in_req_bytes = '0;
    heap_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero sizes, the smallest and largest requests, every
    // opcode, frees of null, interior, misaligned and already-free
    // addresses, and the reallocate corner cases.
    send_request(OP_ALLOC, 0, 0, 0);
    send_request(OP_ALLOC, 0, 1, 1);
    send_request(OP_ALLOC, 0, 8, 0);
    send_request(OP_ALLOC, 0, 9, 0);
    send_request(OP_ALLOC, 0, 4080, 2);
    send_request(OP_ALLOC, 0, 1 << 20, 0);
    send_request(OP_ALLOC, 0, (1 << REQ_W) - 1, 0);
    send_request(OP_FREE, 0, 0, 0);
    a = held[0];
    send_request(OP_FREE, a + 8, 0, 0);
    send_request(OP_FREE, a + 3, 0, 1);
    send_request(OP_FREE, (1 << ADDR_W) - 8, 0, 0);
    send_request(OP_FREE, a, 0, 0);
    send_request(OP_FREE, a, 0, 0);
    send_request(OP_REALLOC, 0, 40, 0);
    send_request(OP_REALLOC, held[0], 100, 3);
    send_request(OP_REALLOC, held[0], 0, 0);
    send_request(OP_REALLOC, held[0], 1 << 20, 0);
    send_request(OP_NOP, (1 << ADDR_W) - 1, (1 << REQ_W) - 1, 0);
    send_request(OP_ALLOC, 0, 900000, 0);
    send_request(OP_ALLOC, 0, 200000, 0);
    send_request(OP_FREE, held[held.size() - 1], 0, 0);

    // Random part: well-formed allocate and release traffic on the blocks
    // actually held, with some malformed addresses and idle requests.
    repeat (N_RANDOM) begin
      p = $urandom_range(0, 99);
      if (p < 42 || held.size() == 0)
        send_request(OP_ALLOC, 0, pick_size(), pick_gap());
      else if (p < 72)
        send_request(OP_FREE, pick_held(), 0, pick_gap());
      else if (p < 85)
        send_request(OP_REALLOC, ($urandom_range(0, 9) == 0) ? 0 : pick_held(),
                     pick_size(), pick_gap());
      else if (p < 95)
        send_request(opcode_t'($urandom_range(OP_FREE, OP_REALLOC)), pick_bad_addr(),
                     pick_size(), pick_gap());
      else
        send_request(OP_NOP, $urandom(), $urandom(), pick_gap());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests sent, %0d grants checked, heap top reached %0d bytes",
             n_sent, sb.checked, brk_top);
    if (sb.errors == 0) begin
      $display("tb_next_fit_boundary_tag_allocator_unit passed");
    end else begin
      $display("tb_next_fit_boundary_tag_allocator_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nfbta_pkg.sv
hw/rtl/nfbta_ram.sv
hw/rtl/next_fit_boundary_tag_allocator_unit.sv
hw/rtl/nfbta_checker.sv
test/tb_next_fit_boundary_tag_allocator_unit.sv
